// ----- design/md5_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and step functions of the MD5 digest engine:
// controller states, command and status groups, initial chaining values,
// the additive constant table, the rotation table and the per-step helpers.
// ----------------------------------------------------------------------------
package md5_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;   // OR the input byte into the block and bump the count
        logic pad;      // OR the 0x80 pad byte in at the current position
        logic len;      // write the bit length into words 14 and 15
        logic load;     // copy the chaining words into the working registers
        logic round;    // run one compression step
        logic add;      // fold the working registers into the chain, clear block
        logic emit;     // move digest words into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_full;   // next byte lands in the last place of the block
        logic pos_late;   // pad byte lands where the length field sits
        logic step_last;  // current compression step is the sixty-fourth
        logic out_free;   // output register can take a word this cycle
        logic emit_last;  // word d is the next one to be emitted
    } t_stat;

    // Round codes.
    localparam logic [1:0] RND_F = 2'd0;
    localparam logic [1:0] RND_G = 2'd1;
    localparam logic [1:0] RND_H = 2'd2;
    localparam logic [1:0] RND_I = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Initial chaining values a, b, c, d.
    localparam logic [31:0] INIT_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // Additive constants, one per step.
    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotation amounts, indexed by round and by the step's low two bits.
    localparam logic [4:0] SHIFT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a step.
    function automatic logic [3:0] md5_g(input logic [5:0] step);
        logic [3:0] idx;
        logic [3:0] res;
        idx = step[3:0];
        case (step[5:4])
            RND_F:   res = idx;
            RND_G:   res = (idx << 2) + idx + 4'd1;
            RND_H:   res = (idx << 1) + idx + 4'd5;
            default: res = (idx << 3) - idx;
        endcase
        return res;
    endfunction

    // Non-linear function of a round.
    function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        case (rnd)
            RND_F:   res = (b & c) | (~b & d);
            RND_G:   res = (d & b) | (~d & c);
            RND_H:   res = b ^ c ^ d;
            default: res = c ^ (b | ~d);
        endcase
        return res;
    endfunction

    // Rotate left by s places.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] wide;
        wide = {x, x} << s;
        return wide[63:32];
    endfunction

endpackage
`default_nettype wire

// ----- design/md5_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5_ctrl
// Controller of the MD5 digest engine. Takes input words while idle, starts a
// compression when a block fills, sequences padding, length and the final
// compressions, and hands the digest words to the output register.
// ----------------------------------------------------------------------------
module md5_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_byte_valid,
    input  wire logic          i_last,
    input  wire md5_pkg::t_stat i_stat,
    output md5_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);
    import md5_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // State registers; r_ret is where to go once a compression is folded in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_byte_valid && i_stat.pos_full) begin
                        n_state = S_LOAD;
                        n_ret   = i_last ? S_PAD : S_IDLE;
                    end else if (i_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (i_stat.pos_late) begin
                    n_state = S_LOAD;
                    n_ret   = S_LEN;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_state = S_LOAD;
                n_ret   = S_EMIT;
            end
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: begin
                if (i_stat.step_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD:   n_state = r_ret;
            S_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands and input handshake.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.absorb = i_in_valid && i_byte_valid;
            end
            S_PAD:   o_cmd.pad   = 1'b1;
            S_LEN:   o_cmd.len   = 1'b1;
            S_LOAD:  o_cmd.load  = 1'b1;
            S_ROUND: o_cmd.round = 1'b1;
            S_ADD:   o_cmd.add   = 1'b1;
            S_EMIT:  o_cmd.emit  = 1'b1;
            default: o_cmd       = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/md5_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5_dpath
// Datapath of the MD5 digest engine: block buffer, byte count, chaining
// words, the one-step-per-cycle compression unit and the output register.
// ----------------------------------------------------------------------------
module md5_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire md5_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_out_ready,
    output md5_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic [31:0]        o_digest_word,
    output logic [1:0]         o_word_index,
    output logic               o_last_word
);
    import md5_pkg::*;

    logic [31:0] r_block [16];
    logic [31:0] n_block [16];
    logic [31:0] r_chain [4];
    logic [60:0] r_count;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_mk;
    logic [5:0]  r_step;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [1:0]  r_out_idx;
    logic [1:0]  r_emit_idx;

    logic [3:0]  w_idx;
    logic [4:0]  lane_sh;
    logic [63:0] bit_len;
    logic [5:0]  step_next;
    logic [5:0]  mk_step;
    logic [31:0] step_sum;
    logic [31:0] step_b;
    logic        out_free;

    assign w_idx   = r_count[5:2];
    assign lane_sh = {r_count[1:0], 3'b000};
    assign bit_len = {r_count, 3'b000};
    assign out_free = !r_out_valid || i_out_ready;

    // Block buffer update: byte insertion, padding, length and clearing.
    always_comb begin
        n_block = r_block;
        if (i_cmd.add) begin
            for (int k = 0; k < 16; k++) begin
                n_block[k] = '0;
            end
        end else if (i_cmd.absorb) begin
            n_block[w_idx] = r_block[w_idx] | ({24'd0, i_data_byte} << lane_sh);
        end else if (i_cmd.pad) begin
            n_block[w_idx] = r_block[w_idx] | ({24'd0, PAD_BYTE} << lane_sh);
        end else if (i_cmd.len) begin
            n_block[14] = bit_len[31:0];
            n_block[15] = bit_len[63:32];
        end
    end

    // One compression step; the message word plus constant is prefetched.
    assign step_next = r_step + 6'd1;
    assign mk_step   = i_cmd.load ? 6'd0 : step_next;
    assign step_sum  = r_a + md5_f(r_step[5:4], r_b, r_c, r_d) + r_mk;
    assign step_b    = r_b + rotl32(step_sum, SHIFT_TAB[{r_step[5:4], r_step[1:0]}]);

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_block[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_chain[k] <= INIT_WORDS[k];
            end
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_emit_idx  <= '0;
        end else begin
            r_block <= n_block;
            if (i_cmd.absorb) begin
                r_count <= r_count + 61'd1;
            end
            if (i_cmd.load) begin
                r_step <= '0;
            end else if (i_cmd.round) begin
                r_step <= step_next;
            end
            if (i_cmd.add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
            // Digest words leave one at a time; after word d the message state restarts.
            if (i_cmd.emit && out_free) begin
                r_out_valid <= 1'b1;
                r_emit_idx  <= r_emit_idx + 2'd1;
                if (r_emit_idx == 2'd3) begin
                    for (int k = 0; k < 4; k++) begin
                        r_chain[k] <= INIT_WORDS[k];
                    end
                    r_count <= '0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.round) begin
            r_mk <= r_block[md5_g(mk_step)] + K_TAB[mk_step];
        end
        if (i_cmd.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= step_b;
        end
        if (i_cmd.emit && out_free) begin
            r_out_word <= r_chain[r_emit_idx];
            r_out_idx  <= r_emit_idx;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.pos_full  = (r_count[5:0] == 6'd63);
        o_stat.pos_late  = (r_count[5:3] == 3'd7);
        o_stat.step_last = (r_step == 6'd63);
        o_stat.out_free  = out_free;
        o_stat.emit_last = (r_emit_idx == 2'd3);
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == 2'd3);

endmodule
`default_nettype wire

// ----- design/md5_digest_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5_digest_engine
// Streaming MD5 message digest: one message byte per input word, four
// 32-bit digest words out after the word marked last.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_ready   i_data_byte, i_byte_valid, i_last
//  output    out        o_out_valid / i_out_ready o_digest_word, o_word_index,
//                                                 o_last_word
//
//  A byte is taken every cycle while the controller is idle.
//  The word that fills a block holds the input through a load state, 64
//  compression steps on a single shared step unit, and a fold state.
//  The word marked last costs a pad state, a length state, one or two
//  compressions and four output words, one per cycle while i_out_ready is high.
//  Synchronous active-low reset; the output register holds its word under stall.
// ----------------------------------------------------------------------------
module md5_digest_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [1:0]       o_word_index,
    output logic             o_last_word
);
    import md5_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencing.
    md5_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_in_ready   (o_in_ready)
    );

    // Storage, compression and output register.
    md5_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .i_out_ready   (i_out_ready),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
`default_nettype wire
